>>> hw/rtl/dpw_pkg.sv
// Shared types, widths and register codes of the depth pixel to world point block.
package dpw_pkg;

	// Field widths
	localparam int DEPTH_W = 16;
	localparam int PIX_W   = 11;
	localparam int WORLD_W = 24;

	// Configuration port
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// Pixel queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Register indexes; index 7 selects nothing
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRINCIPAL_POINT = 3'd0,
		REG_INVERSE_FOCAL   = 3'd1,
		REG_DEPTH_LIMIT     = 3'd2,
		REG_ROTATION_ROW_X  = 3'd3,
		REG_ROTATION_ROW_Y  = 3'd4,
		REG_ROTATION_ROW_Z  = 3'd5,
		REG_TRANSLATION     = 3'd6
	} reg_index_t;

	// Reset values: cx 325.5, cy 253.5, 1/518, 1/519, identity pose
	localparam logic [31:0] PRINCIPAL_POINT_RST = 32'd265819224;
	localparam logic [63:0] INVERSE_FOCAL_RST   = 64'd138839112842884;
	localparam logic [15:0] DEPTH_LIMIT_RST     = 16'd7000;
	localparam logic [47:0] ROTATION_ROW_X_RST  = 48'd16384;
	localparam logic [47:0] ROTATION_ROW_Y_RST  = 48'd1073741824;
	localparam logic [47:0] ROTATION_ROW_Z_RST  = 48'd70368744177664;
	localparam logic [59:0] TRANSLATION_RST     = 60'd0;

	// Register file contents as seen by front and back
	typedef struct packed {
		logic [31:0] principal_point;
		logic [63:0] inverse_focal;
		logic [15:0] depth_limit;
		logic [47:0] rotation_row_x;
		logic [47:0] rotation_row_y;
		logic [47:0] rotation_row_z;
		logic [59:0] translation;
	} cfg_t;

	// One kept pixel in the queue
	typedef struct packed {
		logic [DEPTH_W-1:0] raw_depth;
		logic [PIX_W-1:0]   column;
		logic [PIX_W-1:0]   row;
	} pixel_t;

endpackage

>>> hw/rtl/dpw_stream_if.sv
// Valid/ready stream interfaces for depth pixels in and world points out.
interface dpw_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [dpw_pkg::DEPTH_W-1:0] raw_depth;
	logic [dpw_pkg::PIX_W-1:0]   column;
	logic [dpw_pkg::PIX_W-1:0]   row;

	modport source (output valid, raw_depth, column, row, input ready);
	modport sink   (input valid, raw_depth, column, row, output ready);
endinterface

interface dpw_point_if;
	logic                               valid;
	logic                               ready;
	logic signed [dpw_pkg::WORLD_W-1:0] world_x;
	logic signed [dpw_pkg::WORLD_W-1:0] world_y;
	logic signed [dpw_pkg::WORLD_W-1:0] world_z;

	modport source (output valid, world_x, world_y, world_z, input ready);
	modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

>>> hw/rtl/dpw_front.sv
// Front end: takes pixels, drops invalid depths, hands kept pixels to the queue.
module dpw_front (
	input  logic            clk,
	input  logic            arst_n,
	dpw_pixel_if.sink       pixel,
	input  dpw_pkg::cfg_t   cfg,
	output logic            push_valid,
	output dpw_pkg::pixel_t push_item,
	input  logic            push_ready
);

	dpw_pkg::pixel_t pix_q;
	logic            keep_q;
	logic            vld_q;
	logic            accept;
	logic            consume;

	// A held pixel leaves when dropped or when the queue takes it
	assign consume     = vld_q && (!keep_q || push_ready);
	assign pixel.ready = !vld_q || consume;
	assign accept      = pixel.valid && pixel.ready;

	assign push_valid = vld_q && keep_q;
	assign push_item  = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (consume) begin
			vld_q <= 1'b0;
		end
	end

	// Classify on the way in: zero depth or depth at/above limit is dropped
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q.raw_depth <= pixel.raw_depth;
			pix_q.column    <= pixel.column;
			pix_q.row       <= pixel.row;
			keep_q          <= (pixel.raw_depth != '0) && (pixel.raw_depth < cfg.depth_limit);
		end
	end

endmodule

>>> hw/rtl/dpw_queue.sv
// Small pixel queue that decouples the front end from the math pipeline.
module dpw_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	input  dpw_pkg::pixel_t            push_item,
	output logic                       push_ready,
	output logic                       pop_valid,
	output dpw_pkg::pixel_t            pop_item,
	input  logic                       pop_ready,
	output logic [dpw_pkg::QCNT_W-1:0] count
);

	dpw_pkg::pixel_t             mem_q [dpw_pkg::QUEUE_DEPTH];
	logic [dpw_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [dpw_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [dpw_pkg::QCNT_W-1:0]  count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = count_q != dpw_pkg::QCNT_W'(dpw_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + dpw_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + dpw_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + dpw_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - dpw_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> hw/rtl/dpw_back.sv
// Back end: eight-stage back-projection and rigid transform pipeline.
module dpw_back (
	input  logic            clk,
	input  logic            arst_n,
	input  dpw_pkg::cfg_t   cfg,
	input  logic            pop_valid,
	input  dpw_pkg::pixel_t pop_item,
	output logic            pop_ready,
	dpw_point_if.source     point
);

	localparam int STAGES = 8;
	localparam int DW     = dpw_pkg::DEPTH_W;
	localparam int MAG_W  = 16;
	localparam int DIFF_W = MAG_W + 1;
	localparam int MUL1_W = MAG_W + DW;
	localparam int MUL2_W = 64;
	localparam int RND_W  = MUL2_W - 24;
	localparam int CAM_W  = RND_W + 1;
	localparam int CAMZ_W = DW + 5;
	localparam int PROD_W = CAM_W + 16;
	localparam int TB_W   = 20 + 14;
	localparam int ACC_W  = PROD_W + 3;
	localparam int Q_W    = ACC_W - 14;
	localparam int WW     = dpw_pkg::WORLD_W;

	// Stage valid bits and per-stage advance
	logic [STAGES:1] stage_vld_q;
	logic [STAGES:1] adv;

	always_comb begin
		adv[STAGES] = !stage_vld_q[STAGES] || point.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			adv[k] = !stage_vld_q[k] || adv[k+1];
		end
	end

	assign pop_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[1]) begin
				stage_vld_q[1] <= pop_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: 16u - cx and 16v - cy as sign and magnitude
	logic signed [DIFF_W-1:0] diff_x;
	logic signed [DIFF_W-1:0] diff_y;
	logic [MAG_W-1:0]         mag_x_s1, mag_y_s1;
	logic                     neg_x_s1, neg_y_s1;
	logic [DW-1:0]            d_s1;

	assign diff_x = signed'({2'b00, pop_item.column, 4'b0000})
		- signed'({1'b0, cfg.principal_point[15:0]});
	assign diff_y = signed'({2'b00, pop_item.row, 4'b0000})
		- signed'({1'b0, cfg.principal_point[31:16]});

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			neg_x_s1 <= diff_x[DIFF_W-1];
			neg_y_s1 <= diff_y[DIFF_W-1];
			mag_x_s1 <= diff_x[DIFF_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
			mag_y_s1 <= diff_y[DIFF_W-1] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
			d_s1     <= pop_item.raw_depth;
		end
	end

	// Stage 2: magnitude times depth
	logic [MUL1_W-1:0] mx_s2, my_s2;
	logic              neg_x_s2, neg_y_s2;
	logic [DW-1:0]     d_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mx_s2    <= MUL1_W'(mag_x_s1) * MUL1_W'(d_s1);
			my_s2    <= MUL1_W'(mag_y_s1) * MUL1_W'(d_s1);
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			d_s2     <= d_s1;
		end
	end

	// Stage 3: times reciprocal focal length (32x32)
	logic [MUL2_W-1:0] px_s3, py_s3;
	logic              neg_x_s3, neg_y_s3;
	logic [DW-1:0]     d_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			px_s3    <= MUL2_W'(mx_s2) * MUL2_W'(cfg.inverse_focal[31:0]);
			py_s3    <= MUL2_W'(my_s2) * MUL2_W'(cfg.inverse_focal[63:32]);
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			d_s3     <= d_s2;
		end
	end

	// Stage 4: round the magnitude to nearest, drop 24 fraction bits
	logic [MUL2_W-1:0] px_rnd, py_rnd;
	logic [RND_W-1:0]  rx_s4, ry_s4;
	logic              neg_x_s4, neg_y_s4;
	logic [DW-1:0]     d_s4;

	assign px_rnd = px_s3 + (MUL2_W'(1) << 23);
	assign py_rnd = py_s3 + (MUL2_W'(1) << 23);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			rx_s4    <= px_rnd[MUL2_W-1:24];
			ry_s4    <= py_rnd[MUL2_W-1:24];
			neg_x_s4 <= neg_x_s3;
			neg_y_s4 <= neg_y_s3;
			d_s4     <= d_s3;
		end
	end

	// Stage 5: apply sign, form camera point (z is depth in Q.4)
	logic signed [CAM_W-1:0]  cam_x_pos, cam_y_pos;
	logic signed [CAM_W-1:0]  cam_x_s5, cam_y_s5;
	logic signed [CAMZ_W-1:0] cam_z_s5;

	assign cam_x_pos = signed'({1'b0, rx_s4});
	assign cam_y_pos = signed'({1'b0, ry_s4});

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			cam_x_s5 <= neg_x_s4 ? -cam_x_pos : cam_x_pos;
			cam_y_s5 <= neg_y_s4 ? -cam_y_pos : cam_y_pos;
			cam_z_s5 <= signed'({1'b0, d_s4, 4'b0000});
		end
	end

	// Stage 6: nine rotation products
	logic [47:0]              rot_row [3];
	logic signed [15:0]       rot_c   [3][3];
	logic signed [PROD_W-1:0] prod_s6 [3][3];

	assign rot_row[0] = cfg.rotation_row_x;
	assign rot_row[1] = cfg.rotation_row_y;
	assign rot_row[2] = cfg.rotation_row_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rot_c[i][j] = signed'(rot_row[i][16*j +: 16]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int i = 0; i < 3; i++) begin
				prod_s6[i][0] <= PROD_W'(rot_c[i][0]) * PROD_W'(cam_x_s5);
				prod_s6[i][1] <= PROD_W'(rot_c[i][1]) * PROD_W'(cam_y_s5);
				prod_s6[i][2] <= PROD_W'(rot_c[i][2]) * PROD_W'(cam_z_s5);
			end
		end
	end

	// Stage 7: partial sums; translation scaled by 2^14 carries the half-LSB bias
	logic signed [TB_W-1:0]  tbias  [3];
	logic signed [ACC_W-1:0] sum_a_s7 [3];
	logic signed [ACC_W-1:0] sum_b_s7 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tbias[i] = signed'({cfg.translation[20*i +: 20], 14'd8192});
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			for (int i = 0; i < 3; i++) begin
				sum_a_s7[i] <= ACC_W'(prod_s6[i][0]) + ACC_W'(prod_s6[i][1]);
				sum_b_s7[i] <= ACC_W'(prod_s6[i][2]) + ACC_W'(tbias[i]);
			end
		end
	end

	// Stage 8: final sum, floor shift, saturate to 24 bits
	logic signed [ACC_W-1:0] total [3];
	logic signed [Q_W-1:0]   quo   [3];
	logic signed [WW-1:0]    world [3];
	logic signed [WW-1:0]    world_s8 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			total[i] = sum_a_s7[i] + sum_b_s7[i];
			quo[i]   = total[i][ACC_W-1:14];
			if ((&quo[i][Q_W-1:WW-1]) || !(|quo[i][Q_W-1:WW-1])) begin
				world[i] = quo[i][WW-1:0];
			end else begin
				world[i] = quo[i][Q_W-1] ? signed'({1'b1, {(WW-1){1'b0}}})
					: signed'({1'b0, {(WW-1){1'b1}}});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			for (int i = 0; i < 3; i++) begin
				world_s8[i] <= world[i];
			end
		end
	end

	assign point.valid   = stage_vld_q[STAGES];
	assign point.world_x = world_s8[0];
	assign point.world_y = world_s8[1];
	assign point.world_z = world_s8[2];

endmodule

>>> hw/rtl/depth_pixel_to_world_point.sv
// Top level: register file, front end, pixel queue and transform pipeline.

// Takes one depth pixel per clock unless stalled and returns at most one world
// point per pixel, one per clock when the output side keeps up. Pixels with zero
// depth or depth at or above depth_limit give no point. A kept pixel passes
// through the front end register, the four-entry pixel queue and the eight
// back-projection and pose pipeline stages, whose two chained multiplies
// (offset times depth, then times 1/f) and the rotation products set the
// pipeline depth. Stalls on the point side fill the output stage, then the
// pipeline, then the queue before pixel ready drops. The user must write
// registers through cfg_we/cfg_index/cfg_data only while no pixel is in
// flight; the block itself does not enforce this.
module depth_pixel_to_world_point (
	input  logic                           clk,
	input  logic                           arst_n,
	dpw_pixel_if.sink                      pixel,
	dpw_point_if.source                    point,
	input  logic                           cfg_we,
	input  logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data
);

	dpw_pkg::cfg_t               cfg_q;
	logic                        q_push;
	logic                        q_push_valid;
	logic                        q_push_ready;
	dpw_pkg::pixel_t             q_push_item;
	logic                        q_pop;
	logic                        q_pop_valid;
	logic                        q_pop_ready;
	dpw_pkg::pixel_t             q_pop_item;
	logic [dpw_pkg::QCNT_W-1:0]  q_count;

	// Register file; out-of-range index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.principal_point <= dpw_pkg::PRINCIPAL_POINT_RST;
			cfg_q.inverse_focal   <= dpw_pkg::INVERSE_FOCAL_RST;
			cfg_q.depth_limit     <= dpw_pkg::DEPTH_LIMIT_RST;
			cfg_q.rotation_row_x  <= dpw_pkg::ROTATION_ROW_X_RST;
			cfg_q.rotation_row_y  <= dpw_pkg::ROTATION_ROW_Y_RST;
			cfg_q.rotation_row_z  <= dpw_pkg::ROTATION_ROW_Z_RST;
			cfg_q.translation     <= dpw_pkg::TRANSLATION_RST;
		end else if (cfg_we) begin
			case (dpw_pkg::reg_index_t'(cfg_index))
				dpw_pkg::REG_PRINCIPAL_POINT: cfg_q.principal_point <= cfg_data[31:0];
				dpw_pkg::REG_INVERSE_FOCAL:   cfg_q.inverse_focal   <= cfg_data[63:0];
				dpw_pkg::REG_DEPTH_LIMIT:     cfg_q.depth_limit     <= cfg_data[15:0];
				dpw_pkg::REG_ROTATION_ROW_X:  cfg_q.rotation_row_x  <= cfg_data[47:0];
				dpw_pkg::REG_ROTATION_ROW_Y:  cfg_q.rotation_row_y  <= cfg_data[47:0];
				dpw_pkg::REG_ROTATION_ROW_Z:  cfg_q.rotation_row_z  <= cfg_data[47:0];
				dpw_pkg::REG_TRANSLATION:     cfg_q.translation     <= cfg_data[59:0];
				default: ;
			endcase
		end
	end

	dpw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.cfg        (cfg_q),
		.push_valid (q_push_valid),
		.push_item  (q_push_item),
		.push_ready (q_push_ready)
	);

	dpw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_item  (q_push_item),
		.push_ready (q_push_ready),
		.pop_valid  (q_pop_valid),
		.pop_item   (q_pop_item),
		.pop_ready  (q_pop_ready),
		.count      (q_count)
	);

	dpw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (q_pop_valid),
		.pop_item  (q_pop_item),
		.pop_ready (q_pop_ready),
		.point     (point)
	);

	assign q_push = q_push_valid && q_push_ready;
	assign q_pop  = q_pop_valid && q_pop_ready;

	// A pixel with no measurement never reaches the queue
	a_no_zero_depth_queued: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_push_item.raw_depth != '0)
		else $error("zero-depth pixel pushed into queue");

	// Queue never written while full
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_count < dpw_pkg::QCNT_W'(dpw_pkg::QUEUE_DEPTH))
		else $error("pixel queue overflow");

	// Fill count tracks transfers on both sides
	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		##1 q_count == $past(q_count) + dpw_pkg::QCNT_W'($past(q_push))
			- dpw_pkg::QCNT_W'($past(q_pop)))
		else $error("pixel queue count mismatch");

endmodule

>>> sim/depth_pixel_to_world_point_test.sv
// Testbench for depth_pixel_to_world_point: directed and random pixels vs a predictor.
module depth_pixel_to_world_point_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Index that selects no register
	localparam logic [dpw_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
	// Cycles to let a dropped pixel clear the front end before a register write
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PER_PHASE = 362;

	typedef struct packed {
		logic [dpw_pkg::WORLD_W-1:0] x;
		logic [dpw_pkg::WORLD_W-1:0] y;
		logic [dpw_pkg::WORLD_W-1:0] z;
	} point_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [dpw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data;

	dpw_pixel_if pixel_bus ();
	dpw_point_if point_bus ();

	depth_pixel_to_world_point dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel_bus),
		.point     (point_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the register file and the points still owed by the block
	dpw_pkg::cfg_t camera_cfg;
	point_t expected_points[$];
	int error_count = 0;
	int unsigned pixel_gap_pct = 0;
	int unsigned point_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("depth_pixel_to_world_point test failed");
		$finish;
	end

	// Offset from the principal point times depth times 1/f, rounded on the magnitude
	function automatic longint back_project(logic [dpw_pkg::PIX_W-1:0] pix,
			logic [15:0] centre, logic [dpw_pkg::DEPTH_W-1:0] depth, logic [31:0] inv_f);
		longint delta;
		longint pix16;
		longint c;
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] r;
		pix16 = {pix, 4'b0000};
		c = centre;
		delta = pix16 - c;
		mag = (delta < 0) ? -delta : delta;
		prod = mag * depth * inv_f;
		r = (prod + 64'd8388608) >> 24;
		return (delta < 0) ? -longint'(r) : longint'(r);
	endfunction

	// One row of R * cam + t, rounded half up and saturated to 24 bits
	function automatic logic [dpw_pkg::WORLD_W-1:0] pose_row(logic [47:0] rot,
			logic [19:0] t, longint cam_x, longint cam_y, longint cam_z);
		longint acc;
		longint r0;
		longint r1;
		longint r2;
		longint q;
		acc = $signed(t);
		r0 = $signed(rot[15:0]);
		r1 = $signed(rot[31:16]);
		r2 = $signed(rot[47:32]);
		acc = acc * 16384 + r0 * cam_x + r1 * cam_y + r2 * cam_z;
		q = (acc + 8192) >>> 14;
		if (q > 64'sd8388607) q = 64'sd8388607;
		if (q < -64'sd8388608) q = -64'sd8388608;
		return q[dpw_pkg::WORLD_W-1:0];
	endfunction

	// Returns 1 with the world point when the pixel is kept
	function automatic bit predict_point(logic [dpw_pkg::DEPTH_W-1:0] depth,
			logic [dpw_pkg::PIX_W-1:0] u, logic [dpw_pkg::PIX_W-1:0] v, output point_t pt);
		longint cam_x;
		longint cam_y;
		longint cam_z;
		pt = '0;
		if (depth == 0 || depth >= camera_cfg.depth_limit) return 1'b0;
		cam_x = back_project(u, camera_cfg.principal_point[15:0], depth,
			camera_cfg.inverse_focal[31:0]);
		cam_y = back_project(v, camera_cfg.principal_point[31:16], depth,
			camera_cfg.inverse_focal[63:32]);
		cam_z = longint'(depth) * 16;
		pt.x = pose_row(camera_cfg.rotation_row_x, camera_cfg.translation[19:0],
			cam_x, cam_y, cam_z);
		pt.y = pose_row(camera_cfg.rotation_row_y, camera_cfg.translation[39:20],
			cam_x, cam_y, cam_z);
		pt.z = pose_row(camera_cfg.rotation_row_z, camera_cfg.translation[59:40],
			cam_x, cam_y, cam_z);
		return 1'b1;
	endfunction

	// Register write on the config port, mirrored into the predictor
	task automatic program_register(logic [dpw_pkg::CFG_IDX_W-1:0] idx,
			logic [dpw_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dpw_pkg::REG_PRINCIPAL_POINT: camera_cfg.principal_point = data[31:0];
			dpw_pkg::REG_INVERSE_FOCAL:   camera_cfg.inverse_focal = data;
			dpw_pkg::REG_DEPTH_LIMIT:     camera_cfg.depth_limit = data[15:0];
			dpw_pkg::REG_ROTATION_ROW_X:  camera_cfg.rotation_row_x = data[47:0];
			dpw_pkg::REG_ROTATION_ROW_Y:  camera_cfg.rotation_row_y = data[47:0];
			dpw_pkg::REG_ROTATION_ROW_Z:  camera_cfg.rotation_row_z = data[47:0];
			dpw_pkg::REG_TRANSLATION:     camera_cfg.translation = data[59:0];
			default: ;
		endcase
	endtask

	// Drop valid and wait for every owed point
	task automatic wait_for_points();
		pixel_bus.valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
	endtask

	// Block fully idle, including pixels that give no point
	task automatic quiesce_pipeline();
		wait_for_points();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One pixel transfer with an optional random gap ahead of it; valid stays high after
	task automatic send_pixel(logic [dpw_pkg::DEPTH_W-1:0] depth,
			logic [dpw_pkg::PIX_W-1:0] u, logic [dpw_pkg::PIX_W-1:0] v);
		point_t pt;
		if ($urandom_range(99) < pixel_gap_pct) begin
			pixel_bus.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < pixel_gap_pct) @(posedge clk);
		end
		pixel_bus.valid <= 1'b1;
		pixel_bus.raw_depth <= depth;
		pixel_bus.column <= u;
		pixel_bus.row <= v;
		@(posedge clk);
		while (!pixel_bus.ready) @(posedge clk);
		if (predict_point(depth, u, v, pt)) expected_points = {expected_points, pt};
	endtask

	function automatic logic [dpw_pkg::CFG_DATA_W-1:0] random_rotation_row(bit extreme);
		logic [15:0] e0;
		logic [15:0] e1;
		logic [15:0] e2;
		if (extreme) return {$urandom, $urandom};
		e0 = 16'($urandom_range(32768) - 16384);
		e1 = 16'($urandom_range(32768) - 16384);
		e2 = 16'($urandom_range(32768) - 16384);
		return {16'h0000, e2, e1, e0};
	endfunction

	// Point stream: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		point_t want;
		if (arst_n && point_bus.valid && point_bus.ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected world point x=%0d y=%0d z=%0d", point_bus.world_x,
					point_bus.world_y, point_bus.world_z);
				error_count++;
			end else begin
				want = expected_points.pop_front();
				if (point_bus.world_x !== want.x) begin
					$error("world_x: expected %0d, got %0d", $signed(want.x), point_bus.world_x);
					error_count++;
				end
				if (point_bus.world_y !== want.y) begin
					$error("world_y: expected %0d, got %0d", $signed(want.y), point_bus.world_y);
					error_count++;
				end
				if (point_bus.world_z !== want.z) begin
					$error("world_z: expected %0d, got %0d", $signed(want.z), point_bus.world_z);
					error_count++;
				end
			end
		end
	end

	// Receiver back-pressure
	initial begin
		point_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			point_bus.ready <= ($urandom_range(99) >= point_stall_pct);
		end
	end

	// Reset configuration: depth edges, image corners, pixels near the principal point
	task automatic test_reset_extremes();
		pixel_gap_pct = 30;
		point_stall_pct = 30;
		send_pixel(16'd0, 11'd0, 11'd0);
		send_pixel(16'd1, 11'd0, 11'd0);
		send_pixel(16'd6999, 11'd2047, 11'd2047);
		send_pixel(16'd7000, 11'd100, 11'd100);
		send_pixel(16'd65535, 11'd2047, 11'd0);
		send_pixel(16'd1000, 11'd0, 11'd2047);
		send_pixel(16'd1000, 11'd2047, 11'd0);
		send_pixel(16'd4000, 11'd325, 11'd253);
		send_pixel(16'd4000, 11'd326, 11'd254);
	endtask

	// Extreme register values, masked upper bits, the unused index and a zero limit
	task automatic test_register_extremes();
		quiesce_pipeline();
		program_register(dpw_pkg::REG_PRINCIPAL_POINT, 64'hFFFF_FFFF_0000_0000);
		program_register(dpw_pkg::REG_INVERSE_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
		program_register(dpw_pkg::REG_DEPTH_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
		program_register(dpw_pkg::REG_ROTATION_ROW_X, 64'hABCD_7FFF_7FFF_7FFF);
		program_register(dpw_pkg::REG_ROTATION_ROW_Y, 64'h1234_8000_8000_8000);
		program_register(dpw_pkg::REG_ROTATION_ROW_Z, 64'hFFFF_0000_0000_4000);
		program_register(dpw_pkg::REG_TRANSLATION,
			{4'hF, 20'h12345, 20'h80000, 20'h7FFFF});
		send_pixel(16'd65534, 11'd2047, 11'd2047);
		send_pixel(16'd65535, 11'd2047, 11'd2047);
		send_pixel(16'd1, 11'd0, 11'd0);
		send_pixel(16'd300, 11'd1024, 11'd5);

		// Centre beyond the image: every offset negative
		quiesce_pipeline();
		program_register(dpw_pkg::REG_PRINCIPAL_POINT, 64'h0000_0000_FFFF_FFFF);
		program_register(dpw_pkg::REG_INVERSE_FOCAL, {32'h0000_8000, 32'h0000_0000});
		send_pixel(16'd65534, 11'd0, 11'd2047);
		send_pixel(16'd300, 11'd1024, 11'd5);

		// Write to the unused index changes nothing
		quiesce_pipeline();
		program_register(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_pixel(16'd5000, 11'd640, 11'd480);

		// Zero limit drops everything
		quiesce_pipeline();
		program_register(dpw_pkg::REG_DEPTH_LIMIT, 64'd0);
		send_pixel(16'd1, 11'd0, 11'd0);
		send_pixel(16'd65535, 11'd2047, 11'd2047);
		send_pixel(16'd32768, 11'd1, 11'd1);
	endtask

	// Random poses and pixels under each idling pattern
	task automatic test_random_stream();
		int unsigned gap_pct[4] = '{0, 77, 0, 9};
		int unsigned stall_pct[4] = '{0, 0, 77, 9};
		bit extreme;
		logic [dpw_pkg::DEPTH_W-1:0] depth;
		int unsigned pick;
		for (int phase = 0; phase < 4; phase++) begin
			extreme = (phase == 3);
			quiesce_pipeline();
			pixel_gap_pct = gap_pct[phase];
			point_stall_pct = stall_pct[phase];
			if (extreme) begin
				program_register(dpw_pkg::REG_PRINCIPAL_POINT, {$urandom, $urandom});
				program_register(dpw_pkg::REG_INVERSE_FOCAL, {$urandom, $urandom});
				program_register(dpw_pkg::REG_DEPTH_LIMIT, {$urandom, $urandom});
				program_register(dpw_pkg::REG_TRANSLATION, {$urandom, $urandom});
			end else begin
				program_register(dpw_pkg::REG_PRINCIPAL_POINT,
					{32'h0, 16'($urandom_range(32767)), 16'($urandom_range(32767))});
				program_register(dpw_pkg::REG_INVERSE_FOCAL,
					{32'($urandom_range(80000, 20000)), 32'($urandom_range(80000, 20000))});
				program_register(dpw_pkg::REG_DEPTH_LIMIT,
					(phase == 2) ? 64'd65535 : 64'($urandom_range(65535, 1000)));
				program_register(dpw_pkg::REG_TRANSLATION,
					{4'h0, 20'($urandom), 20'($urandom), 20'($urandom)});
			end
			program_register(dpw_pkg::REG_ROTATION_ROW_X, random_rotation_row(extreme));
			program_register(dpw_pkg::REG_ROTATION_ROW_Y, random_rotation_row(extreme));
			program_register(dpw_pkg::REG_ROTATION_ROW_Z, random_rotation_row(extreme));

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Hold the stream until the pipeline has emptied once per phase
				if (n == RANDOM_PER_PHASE / 2) wait_for_points();
				pick = $urandom_range(9);
				if (pick == 0)
					depth = '0;
				else if (pick == 1 || camera_cfg.depth_limit < 2)
					depth = 16'($urandom_range(65535));
				else
					depth = 16'($urandom_range(camera_cfg.depth_limit - 16'd1, 1));
				send_pixel(depth, 11'($urandom_range(2047)), 11'($urandom_range(2047)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixel_bus.valid = 1'b0;
		pixel_bus.raw_depth = '0;
		pixel_bus.column = '0;
		pixel_bus.row = '0;
		camera_cfg.principal_point = dpw_pkg::PRINCIPAL_POINT_RST;
		camera_cfg.inverse_focal = dpw_pkg::INVERSE_FOCAL_RST;
		camera_cfg.depth_limit = dpw_pkg::DEPTH_LIMIT_RST;
		camera_cfg.rotation_row_x = dpw_pkg::ROTATION_ROW_X_RST;
		camera_cfg.rotation_row_y = dpw_pkg::ROTATION_ROW_Y_RST;
		camera_cfg.rotation_row_z = dpw_pkg::ROTATION_ROW_Z_RST;
		camera_cfg.translation = dpw_pkg::TRANSLATION_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_extremes();
		test_register_extremes();
		test_random_stream();

		quiesce_pipeline();
		if (error_count == 0) begin
			$display("depth_pixel_to_world_point test passed");
		end else begin
			$display("depth_pixel_to_world_point test failed");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dpw_pkg.sv
hw/rtl/dpw_stream_if.sv
hw/rtl/dpw_front.sv
hw/rtl/dpw_queue.sv
hw/rtl/dpw_back.sv
hw/rtl/depth_pixel_to_world_point.sv
sim/depth_pixel_to_world_point_test.sv
